[rtl/assert_macros.svh]
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/mrtu_pkg.sv]
// Package for the Modbus RTU link controller: codes, state types and result record.
`default_nettype none

package mrtu_pkg;

  // Default maximum frame length in bytes, for receive and for transmit
  localparam int MRTU_MAX_FRAME = 256;

  // Field widths
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int CNT_W   = 9;
  localparam int CFG_W   = 8;
  localparam int CFGIX_W = 1;

  // Event codes on the input channel
  localparam logic [OP_W-1:0] OP_BYTE  = 3'd0;
  localparam logic [OP_W-1:0] OP_TXE   = 3'd1;
  localparam logic [OP_W-1:0] OP_EXPRY = 3'd2;
  localparam logic [OP_W-1:0] OP_START = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFGIX_W-1:0] CFG_IS_MASTER = 1'd0;
  localparam logic [CFGIX_W-1:0] CFG_PSWAIT    = 1'd1;
  localparam logic [CFG_W-1:0]   PSWAIT_RST    = 8'd10;

  // Timer commands
  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // Link events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_BUS_RDY = 2'd1;
  localparam logic [1:0] EV_RCVD    = 2'd2;
  localparam logic [1:0] EV_SENT    = 2'd3;

  // Serial direction
  localparam logic [1:0] SER_NONE = 2'd0;
  localparam logic [1:0] SER_RX   = 2'd1;
  localparam logic [1:0] SER_TX   = 2'd2;
  localparam logic [1:0] SER_OFF  = 2'd3;

  // Expiry counter saturation value
  localparam logic [CNT_W-1:0] EXP_MAX = '1;

  typedef enum logic [1:0] {
    RX_INIT = 2'd0,
    RX_IDLE = 2'd1,
    RX_RCV  = 2'd2,
    RX_ERR  = 2'd3
  } rx_phase_t;

  typedef enum logic [1:0] {
    TX_IDLE = 2'd0,
    TX_XMIT = 2'd1,
    TX_END  = 2'd2
  } tx_phase_t;

  // One result record
  typedef struct packed {
    logic              handled;
    logic [1:0]        timer_cmd;
    logic [1:0]        link_event;
    logic              rx_store;
    logic [BYTE_W-1:0] rx_index;
    logic [BYTE_W-1:0] rx_data;
    logic              tx_write;
    logic [BYTE_W-1:0] tx_index;
    logic              queue_pop;
    logic [1:0]        serial_mode;
  } mrtu_result_t;

endpackage

`default_nettype wire

[rtl/modbus_rtu_link_fsm_unit.sv]
// Modbus RTU link-layer controller: T3.5 framing for receive and transmit.
//
// Input channel (in_valid / in_stall): one event per request; in_op selects
// byte received, transmitter empty, T3.5 expiry, start or stop.
// Result channel (out_valid / out_stall): exactly one result per event,
// carrying timer commands, link events, buffer writes, byte offsets to send,
// queue pops and the serial direction.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 is_master,
// index 1 post_send_wait; write only while the block is idle.
// The result is registered, in the result register or in the skid register.
// Throughput: one request per cycle while in_stall is low; the state update
// is a single pass of next-state logic on the link registers.
// A two-entry output buffer (result register plus skid register) lets the
// block take a request while a result is still waiting. in_stall rises only
// when both entries are full, so a stalled receiver holds at most two results.
// Reset (synchronous, rst_n low): receive side to init, transmit side to
// idle, counters cleared, is_master 0, post_send_wait 10, buffer empty.
`default_nettype none

module modbus_rtu_link_fsm_unit #(
  parameter int MAX_FRAME = mrtu_pkg::MRTU_MAX_FRAME
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [mrtu_pkg::CFGIX_W-1:0] cfg_index,
  input  wire logic [mrtu_pkg::CFG_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mrtu_pkg::OP_W-1:0]    in_op,
  input  wire logic [mrtu_pkg::BYTE_W-1:0]  in_rx_byte,
  input  wire logic                         in_queue_has_frame,
  input  wire logic [mrtu_pkg::LEN_W-1:0]   in_frame_length,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_handled,
  output logic [1:0]                        out_timer_cmd,
  output logic [1:0]                        out_link_event,
  output logic                              out_rx_store,
  output logic [mrtu_pkg::BYTE_W-1:0]       out_rx_index,
  output logic [mrtu_pkg::BYTE_W-1:0]       out_rx_data,
  output logic                              out_tx_write,
  output logic [mrtu_pkg::BYTE_W-1:0]       out_tx_index,
  output logic                              out_queue_pop,
  output logic [1:0]                        out_serial_mode
);

  import mrtu_pkg::*;

  localparam logic [CNT_W-1:0] MaxLen = CNT_W'(MAX_FRAME);

  // configuration registers
  logic             is_master_r;
  logic [CFG_W-1:0] pswait_r;

  // link state
  rx_phase_t        rx_phase_r,   rx_phase_nxt;
  tx_phase_t        tx_phase_r,   tx_phase_nxt;
  logic [CNT_W-1:0] rx_count_r,   rx_count_nxt;
  logic [CNT_W-1:0] tx_rem_r,     tx_rem_nxt;
  logic [CNT_W-1:0] tx_total_r,   tx_total_nxt;
  logic [CNT_W-1:0] exp_count_r,  exp_count_nxt;

  // output buffer
  mrtu_result_t res;
  mrtu_result_t out_r,  out_nxt;
  mrtu_result_t skid_r, skid_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;

  logic             accept;
  logic             take;
  logic [CNT_W-1:0] exp_inc;
  logic             wait_done;
  logic [CNT_W-1:0] len_clamped;
  logic [CNT_W-1:0] tx_offset;

  assign accept = in_valid && !skid_valid_r;
  assign take   = out_valid_r && !out_stall;

  // datapath terms for the next-state and result logic
  assign exp_inc     = (exp_count_r < EXP_MAX) ? exp_count_r + CNT_W'(1) : exp_count_r;
  assign wait_done   = !is_master_r || (exp_inc > {1'b0, pswait_r});
  assign len_clamped = (in_frame_length > MaxLen) ? MaxLen : in_frame_length;
  assign tx_offset   = tx_total_r - tx_rem_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_master_r <= 1'b0;
      pswait_r    <= PSWAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IS_MASTER: is_master_r <= cfg_wdata[0];
        CFG_PSWAIT:    pswait_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state of both link machines
  always_comb begin
    rx_phase_nxt  = rx_phase_r;
    tx_phase_nxt  = tx_phase_r;
    rx_count_nxt  = rx_count_r;
    tx_rem_nxt    = tx_rem_r;
    tx_total_nxt  = tx_total_r;
    exp_count_nxt = exp_count_r;
    case (in_op)
      OP_BYTE: begin
        if (tx_phase_r == TX_IDLE) begin
          if (rx_phase_r == RX_IDLE) begin
            rx_count_nxt = CNT_W'(1);
            rx_phase_nxt = RX_RCV;
          end else if (rx_phase_r == RX_RCV) begin
            if (rx_count_r < MaxLen) begin
              rx_count_nxt = rx_count_r + CNT_W'(1);
            end else begin
              rx_phase_nxt = RX_ERR;
            end
          end
        end
      end
      OP_TXE: begin
        if (rx_phase_r == RX_IDLE && tx_phase_r != TX_END && in_queue_has_frame) begin
          if (tx_phase_r == TX_IDLE) begin
            tx_total_nxt = len_clamped;
            tx_rem_nxt   = len_clamped;
            tx_phase_nxt = TX_XMIT;
          end else if (tx_phase_r == TX_XMIT) begin
            if (tx_rem_r != '0) begin
              tx_rem_nxt = tx_rem_r - CNT_W'(1);
            end else begin
              tx_phase_nxt  = TX_END;
              exp_count_nxt = '0;
            end
          end
        end
      end
      OP_EXPRY: begin
        if (tx_phase_r == TX_END) begin
          exp_count_nxt = exp_inc;
          if (wait_done) tx_phase_nxt = TX_IDLE;
        end else begin
          rx_phase_nxt = RX_IDLE;
        end
      end
      OP_START: rx_phase_nxt = RX_INIT;
      default: ;
    endcase
  end

  // result of the current request
  always_comb begin
    res = '0;
    case (in_op)
      OP_BYTE: begin
        if (tx_phase_r == TX_IDLE) begin
          res.handled   = 1'b1;
          res.timer_cmd = TMR_START;
          if (rx_phase_r == RX_IDLE) begin
            res.rx_store = 1'b1;
            res.rx_data  = in_rx_byte;
          end else if (rx_phase_r == RX_RCV && rx_count_r < MaxLen) begin
            res.rx_store = 1'b1;
            res.rx_index = rx_count_r[BYTE_W-1:0];
            res.rx_data  = in_rx_byte;
          end
        end
      end
      OP_TXE: begin
        if (rx_phase_r == RX_IDLE && tx_phase_r != TX_END) begin
          res.handled = 1'b1;
          if (!in_queue_has_frame) begin
            res.serial_mode = SER_RX;
          end else begin
            res.serial_mode = SER_TX;
            if (tx_phase_r == TX_XMIT) begin
              if (tx_rem_r != '0) begin
                res.tx_write = 1'b1;
                res.tx_index = tx_offset[BYTE_W-1:0];
              end else begin
                res.timer_cmd   = TMR_START;
                res.serial_mode = SER_RX;
                res.queue_pop   = 1'b1;
                res.link_event  = EV_SENT;
              end
            end
          end
        end
      end
      OP_EXPRY: begin
        if (tx_phase_r == TX_END) begin
          res.handled = 1'b1;
          if (wait_done) res.timer_cmd = TMR_STOP;
        end else begin
          res.timer_cmd = TMR_STOP;
          if (rx_phase_r == RX_INIT) begin
            res.link_event = EV_BUS_RDY;
          end else if (rx_phase_r == RX_RCV) begin
            res.link_event = EV_RCVD;
          end
        end
      end
      OP_START: begin
        res.handled     = 1'b1;
        res.timer_cmd   = TMR_START;
        res.serial_mode = SER_RX;
      end
      OP_STOP: begin
        res.handled     = 1'b1;
        res.timer_cmd   = TMR_STOP;
        res.serial_mode = SER_OFF;
      end
      default: ;
    endcase
  end

  // link state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r  <= RX_INIT;
      tx_phase_r  <= TX_IDLE;
      rx_count_r  <= '0;
      tx_rem_r    <= '0;
      tx_total_r  <= '0;
      exp_count_r <= '0;
    end else if (accept) begin
      rx_phase_r  <= rx_phase_nxt;
      tx_phase_r  <= tx_phase_nxt;
      rx_count_r  <= rx_count_nxt;
      tx_rem_r    <= tx_rem_nxt;
      tx_total_r  <= tx_total_nxt;
      exp_count_r <= exp_count_nxt;
    end
  end

  // output buffer: result register with a skid entry behind it
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // ports
  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_handled     = out_r.handled;
  assign out_timer_cmd   = out_r.timer_cmd;
  assign out_link_event  = out_r.link_event;
  assign out_rx_store    = out_r.rx_store;
  assign out_rx_index    = out_r.rx_index;
  assign out_rx_data     = out_r.rx_data;
  assign out_tx_write    = out_r.tx_write;
  assign out_tx_index    = out_r.tx_index;
  assign out_queue_pop   = out_r.queue_pop;
  assign out_serial_mode = out_r.serial_mode;

endmodule

`default_nettype wire

[rtl/mrtu_checker.sv]
// Port-level checker for the Modbus RTU link controller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mrtu_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [mrtu_pkg::OP_W-1:0]    in_op,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_handled,
  input wire logic [1:0]                   out_timer_cmd,
  input wire logic [1:0]                   out_link_event,
  input wire logic                         out_rx_store,
  input wire logic [mrtu_pkg::BYTE_W-1:0]  out_rx_index,
  input wire logic [mrtu_pkg::BYTE_W-1:0]  out_rx_data,
  input wire logic                         out_tx_write,
  input wire logic [mrtu_pkg::BYTE_W-1:0]  out_tx_index,
  input wire logic                         out_queue_pop,
  input wire logic [1:0]                   out_serial_mode
);

  import mrtu_pkg::*;

  // a stalled result stays and keeps its buffer indexes and link event
  `MRTU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rx_index) && $stable(out_tx_index) && $stable(out_link_event))

  // buffer positions and data are zero when nothing is stored
  `MRTU_ASSERT_NOW(a_rx_quiet, clk, rst_n, out_valid && !out_rx_store, out_rx_index == '0 && out_rx_data == '0)

  // transmit offset is zero unless a byte goes out
  `MRTU_ASSERT_NOW(a_tx_quiet, clk, rst_n, out_valid && !out_tx_write, out_tx_index == '0)

  // a queue pop always comes with frame sent, timer restart and receive enable
  `MRTU_ASSERT_NOW(a_pop_sent, clk, rst_n, out_valid && out_queue_pop, out_link_event == EV_SENT && out_timer_cmd == TMR_START && out_serial_mode == SER_RX)

  // unhandled events never write the buffer, send a byte or pop the queue
  `MRTU_ASSERT_NOW(a_unhandled, clk, rst_n, out_valid && !out_handled, !out_rx_store && !out_tx_write && !out_queue_pop)

endmodule

bind modbus_rtu_link_fsm_unit mrtu_checker u_mrtu_checker (.*);

`default_nettype wire

[tb/sv/modbus_rtu_link_fsm_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU link controller: directed table, then random events.

module modbus_rtu_link_fsm_unit_test;
  import mrtu_pkg::*;

  localparam int FRAME_MAX   = MRTU_MAX_FRAME;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 425;
  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  // one row of the directed table
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              has;
    logic [LEN_W-1:0]  len;
    logic              fixed;
    mrtu_result_t      want;
  } step_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFGIX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = '0;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic in_queue_has_frame = 1'b0;
  logic [LEN_W-1:0] in_frame_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_handled;
  logic [1:0] out_timer_cmd;
  logic [1:0] out_link_event;
  logic out_rx_store;
  logic [BYTE_W-1:0] out_rx_index;
  logic [BYTE_W-1:0] out_rx_data;
  logic out_tx_write;
  logic [BYTE_W-1:0] out_tx_index;
  logic out_queue_pop;
  logic [1:0] out_serial_mode;

  modbus_rtu_link_fsm_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_rx_byte         (in_rx_byte),
    .in_queue_has_frame (in_queue_has_frame),
    .in_frame_length    (in_frame_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_handled        (out_handled),
    .out_timer_cmd      (out_timer_cmd),
    .out_link_event     (out_link_event),
    .out_rx_store       (out_rx_store),
    .out_rx_index       (out_rx_index),
    .out_rx_data        (out_rx_data),
    .out_tx_write       (out_tx_write),
    .out_tx_index       (out_tx_index),
    .out_queue_pop      (out_queue_pop),
    .out_serial_mode    (out_serial_mode)
  );

  // link state as this bench tracks it
  rx_phase_t link_rx;
  tx_phase_t link_tx;
  logic [CNT_W-1:0] rx_fill;
  logic [CNT_W-1:0] tx_left;
  logic [CNT_W-1:0] tx_len;
  logic [CNT_W-1:0] expiries;
  logic cfg_master;
  logic [CFG_W-1:0] cfg_wait;

  mrtu_result_t pending_results[$];
  mrtu_result_t head;
  step_row_t script[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int requests_acted = 0;
  int frames_out = 0;
  int frames_in = 0;
  int overruns = 0;
  int cycles = 0;
  int burst_left = 0;
  logic goal_send = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("modbus_rtu_link_fsm_unit_test NOT OK");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic mrtu_result_t outcome(input logic h, input logic [1:0] tmr,
      input logic [1:0] ev, input logic st, input logic [7:0] ri, input logic [7:0] rd,
      input logic tw, input logic [7:0] ti, input logic pop, input logic [1:0] ser);
    mrtu_result_t r;
    r.handled = h;
    r.timer_cmd = tmr;
    r.link_event = ev;
    r.rx_store = st;
    r.rx_index = ri;
    r.rx_data = rd;
    r.tx_write = tw;
    r.tx_index = ti;
    r.queue_pop = pop;
    r.serial_mode = ser;
    return r;
  endfunction

  // next link state and the result of one request
  function automatic mrtu_result_t link_next(input logic [OP_W-1:0] op,
      input logic [BYTE_W-1:0] b, input logic has, input logic [LEN_W-1:0] len);
    mrtu_result_t r;
    logic [CNT_W-1:0] offset;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (link_tx == TX_IDLE) begin
          r.handled = 1'b1;
          r.timer_cmd = TMR_START;
          if (link_rx == RX_IDLE) begin
            r.rx_store = 1'b1;
            r.rx_data = b;
            rx_fill = CNT_W'(1);
            link_rx = RX_RCV;
          end else if (link_rx == RX_RCV) begin
            if (rx_fill < FRAME_MAX) begin
              r.rx_store = 1'b1;
              r.rx_index = rx_fill[BYTE_W-1:0];
              r.rx_data = b;
              rx_fill = rx_fill + 1'b1;
            end else begin
              link_rx = RX_ERR;
              overruns++;
            end
          end
        end
      end
      OP_TXE: begin
        if (link_rx == RX_IDLE && link_tx != TX_END) begin
          r.handled = 1'b1;
          if (!has) begin
            r.serial_mode = SER_RX;
          end else begin
            r.serial_mode = SER_TX;
            if (link_tx == TX_IDLE) begin
              tx_len = (len > FRAME_MAX) ? CNT_W'(FRAME_MAX) : len;
              tx_left = tx_len;
              link_tx = TX_XMIT;
            end else if (tx_left != 0) begin
              offset = tx_len - tx_left;
              r.tx_write = 1'b1;
              r.tx_index = offset[BYTE_W-1:0];
              tx_left = tx_left - 1'b1;
            end else begin
              link_tx = TX_END;
              expiries = '0;
              r.timer_cmd = TMR_START;
              r.serial_mode = SER_RX;
              r.queue_pop = 1'b1;
              r.link_event = EV_SENT;
              frames_out++;
            end
          end
        end
      end
      OP_EXPRY: begin
        if (link_tx == TX_END) begin
          if (expiries < EXP_MAX) expiries = expiries + 1'b1;
          if (!cfg_master || expiries > cfg_wait) begin
            link_tx = TX_IDLE;
            r.timer_cmd = TMR_STOP;
          end
          r.handled = 1'b1;
        end else begin
          if (link_rx == RX_INIT) begin
            r.link_event = EV_BUS_RDY;
          end else if (link_rx == RX_RCV) begin
            r.link_event = EV_RCVD;
            frames_in++;
          end
          link_rx = RX_IDLE;
          r.timer_cmd = TMR_STOP;
        end
      end
      OP_START: begin
        link_rx = RX_INIT;
        r.serial_mode = SER_RX;
        r.timer_cmd = TMR_START;
        r.handled = 1'b1;
      end
      OP_STOP: begin
        r.serial_mode = SER_OFF;
        r.timer_cmd = TMR_STOP;
        r.handled = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [8:0] got,
      input logic [8:0] want);
    if (mismatch_count < 30)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 9'd1, 9'd0);
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (out_handled !== head.handled)
          flag_mismatch("handled", 9'(out_handled), 9'(head.handled));
        if (out_timer_cmd !== head.timer_cmd)
          flag_mismatch("timer_cmd", 9'(out_timer_cmd), 9'(head.timer_cmd));
        if (out_link_event !== head.link_event)
          flag_mismatch("link_event", 9'(out_link_event), 9'(head.link_event));
        if (out_rx_store !== head.rx_store)
          flag_mismatch("rx_store", 9'(out_rx_store), 9'(head.rx_store));
        if (out_rx_index !== head.rx_index)
          flag_mismatch("rx_index", 9'(out_rx_index), 9'(head.rx_index));
        if (out_rx_data !== head.rx_data)
          flag_mismatch("rx_data", 9'(out_rx_data), 9'(head.rx_data));
        if (out_tx_write !== head.tx_write)
          flag_mismatch("tx_write", 9'(out_tx_write), 9'(head.tx_write));
        if (out_tx_index !== head.tx_index)
          flag_mismatch("tx_index", 9'(out_tx_index), 9'(head.tx_index));
        if (out_queue_pop !== head.queue_pop)
          flag_mismatch("queue_pop", 9'(out_queue_pop), 9'(head.queue_pop));
        if (out_serial_mode !== head.serial_mode)
          flag_mismatch("serial_mode", 9'(out_serial_mode), 9'(head.serial_mode));
      end
    end
  end

  // drive one request and record what it should produce
  task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
      input logic has, input logic [LEN_W-1:0] len, input logic fixed, input mrtu_result_t want);
    mrtu_result_t model;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    in_queue_has_frame <= has;
    in_frame_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = link_next(op, b, has, len);
    pending_results.push_back(fixed ? want : model);
    requests_sent++;
    if (model != '0) requests_acted++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFGIX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IS_MASTER) cfg_master = val[0];
    else cfg_wait = val;
  endtask

  // pick the next random event, mostly steering toward whole frames
  task automatic choose_event(output logic [OP_W-1:0] op, output logic [BYTE_W-1:0] b,
      output logic has, output logic [LEN_W-1:0] len);
    int roll;
    roll = $urandom_range(99);
    b = BYTE_W'($urandom_range(255));
    has = 1'b1;
    len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(511)) : LEN_W'($urandom_range(15));
    if (roll < 8) begin
      op = OP_W'($urandom_range(7));
      has = 1'($urandom_range(1));
    end else if (roll < 10) begin
      op = ($urandom_range(1) != 0) ? OP_START : OP_STOP;
    end else if (link_tx == TX_END) begin
      op = OP_EXPRY;
    end else if (link_tx == TX_XMIT) begin
      op = (link_rx == RX_IDLE) ? OP_TXE : OP_EXPRY;
      has = ($urandom_range(19) != 0);
      len = LEN_W'($urandom_range(511));
    end else if (goal_send) begin
      if (link_rx != RX_IDLE) begin
        op = OP_EXPRY;
      end else begin
        op = OP_TXE;
        len = ($urandom_range(39) == 0) ? LEN_W'($urandom_range(250, 511))
                                        : LEN_W'($urandom_range(6));
        goal_send = 1'($urandom_range(1));
      end
    end else if (link_rx == RX_INIT) begin
      op = OP_EXPRY;
    end else if (link_rx == RX_IDLE) begin
      op = OP_BYTE;
      burst_left = ($urandom_range(39) == 0) ? $urandom_range(249, 269) : $urandom_range(15);
    end else if (burst_left > 0) begin
      op = OP_BYTE;
      burst_left--;
    end else begin
      // gap closes the frame
      op = OP_EXPRY;
      goal_send = 1'($urandom_range(1));
    end
  endtask

  // stimulus
  initial begin
    logic [OP_W-1:0] op;
    logic [BYTE_W-1:0] b;
    logic has;
    logic [LEN_W-1:0] len;
    int phase_start;
    link_rx = RX_INIT;
    link_tx = TX_IDLE;
    rx_fill = '0;
    tx_left = '0;
    tx_len = '0;
    expiries = '0;
    cfg_master = 1'b0;
    cfg_wait = PSWAIT_RST;

    // directed table, run with reset register values
    script.push_back('{OP_BYTE, 8'hFF, 1'b0, 9'd0, 1'b1,
                       outcome(1, TMR_START, EV_NONE, 0, 0, 0, 0, 0, 0, SER_NONE)});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'h1FF, 1'b1, '0});
    script.push_back('{OP_EXPRY, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(0, TMR_STOP, EV_BUS_RDY, 0, 0, 0, 0, 0, 0, SER_NONE)});
    script.push_back('{OP_BYTE, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(1, TMR_START, EV_NONE, 1, 0, 0, 0, 0, 0, SER_NONE)});
    script.push_back('{OP_BYTE, 8'hA5, 1'b0, 9'd0, 1'b0, '0});
    script.push_back('{OP_BYTE, 8'hFF, 1'b1, 9'h1FF, 1'b0, '0});
    script.push_back('{OP_BAD_LO, 8'h5A, 1'b0, 9'd0, 1'b1, '0});
    script.push_back('{OP_BAD_HI, 8'hFF, 1'b1, 9'h1FF, 1'b1, '0});
    script.push_back('{OP_EXPRY, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(0, TMR_STOP, EV_RCVD, 0, 0, 0, 0, 0, 0, SER_NONE)});
    // empty queue
    script.push_back('{OP_TXE, 8'h00, 1'b0, 9'd4, 1'b1,
                       outcome(1, TMR_NONE, EV_NONE, 0, 0, 0, 0, 0, 0, SER_RX)});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd2, 1'b0, '0});
    // byte while the transmitter is busy
    script.push_back('{OP_BYTE, 8'h3C, 1'b0, 9'd0, 1'b1, '0});
    // length changes mid-send
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd300, 1'b0, '0});
    script.push_back('{OP_TXE, 8'h00, 1'b0, 9'd2, 1'b0, '0});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd0, 1'b0, '0});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd2, 1'b1,
                       outcome(1, TMR_START, EV_SENT, 0, 0, 0, 0, 0, 1, SER_RX)});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd2, 1'b1, '0});
    script.push_back('{OP_BYTE, 8'h11, 1'b0, 9'd0, 1'b1, '0});
    // slave leaves the post-send wait on the first expiry
    script.push_back('{OP_EXPRY, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(1, TMR_STOP, EV_NONE, 0, 0, 0, 0, 0, 0, SER_NONE)});
    script.push_back('{OP_STOP, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(1, TMR_STOP, EV_NONE, 0, 0, 0, 0, 0, 0, SER_OFF)});
    script.push_back('{OP_START, 8'h00, 1'b0, 9'd0, 1'b1,
                       outcome(1, TMR_START, EV_NONE, 0, 0, 0, 0, 0, 0, SER_RX)});
    script.push_back('{OP_EXPRY, 8'h00, 1'b0, 9'd0, 1'b0, '0});
    // oversize frame is clipped
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'h1FF, 1'b0, '0});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd1, 1'b0, '0});
    script.push_back('{OP_TXE, 8'h00, 1'b1, 9'd1, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_event(script[i].op, script[i].data, script[i].has, script[i].len,
                 script[i].fixed, script[i].want);
    wait_drained();

    // random phases: registers and idling change between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_IS_MASTER, 8'd1);
          write_reg(CFG_PSWAIT, 8'd0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_PSWAIT, 8'd255);
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_IS_MASTER, 8'd0);
          write_reg(CFG_PSWAIT, 8'd3);
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        default: begin
          write_reg(CFG_IS_MASTER, 8'd1);
          write_reg(CFG_PSWAIT, 8'd7);
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      phase_start = requests_acted;
      while (requests_acted - phase_start < PHASE_ITEMS) begin
        choose_event(op, b, has, len);
        send_event(op, b, has, len, 1'b0, '0);
        // occasional full drain before going on
        if ($urandom_range(199) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d results from %0d requests across four register settings.",
             results_checked, requests_sent);
    $display("Frames sent %0d, frames received %0d, receive overruns %0d.",
             frames_out, frames_in, overruns);
    if (mismatch_count == 0) begin
      $display("modbus_rtu_link_fsm_unit_test OK");
    end else begin
      $display("modbus_rtu_link_fsm_unit_test NOT OK");
    end
    $finish;
  end

endmodule
